### rtl/tses_pkg.sv
`default_nettype none

package tses_pkg;

  localparam int unsigned SUM_W = 64;
  localparam int unsigned TERM_W = 63;
  localparam int unsigned X_W = 5;
  localparam int unsigned N_W = 5;
  localparam int unsigned SQ_W = 2 * X_W;
  localparam int unsigned P_W = 72;
  localparam int unsigned STEP_BITS = 8;
  localparam int unsigned DIV_CYCLES = P_W / STEP_BITS;
  localparam int unsigned DCNT_W = $clog2(DIV_CYCLES);
  localparam int unsigned DIV_W = 16;
  localparam int unsigned CORE_W = 11;
  localparam int unsigned SINE_PRE_SHIFT = 3;
  localparam int unsigned SINE_SCALE = 25;
  localparam int unsigned SINE_FIRST_DIV = 10;

  typedef enum logic [0:0] {
    KIND_EXP  = 1'b0,
    KIND_SINE = 1'b1
  } kind_e;

  typedef struct packed {
    logic           load;
    logic           prep;
    logic           div_step;
    logic           acc;
    logic           publish;
    logic [N_W-1:0] idx;
  } dp_cmd_t;

endpackage

`default_nettype wire

### rtl/tses_ctrl.sv
`default_nettype none

module tses_ctrl #(
  parameter int unsigned MAX_TERMS = 26
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      kind_i,
  input  wire logic [tses_pkg::N_W-1:0]  term_count_i,
  output logic                           in_stall_o,
  input  wire logic                      out_stall_i,
  output logic                           out_valid_o,
  output tses_pkg::dp_cmd_t              cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_DIV  = 5'b00100,
    S_ACC  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e                         state_q, state_d;
  logic [tses_pkg::N_W-1:0]       idx_q, idx_d;
  logic [tses_pkg::N_W-1:0]       limit_q, limit_d;
  logic [tses_pkg::DCNT_W-1:0]    dcnt_q, dcnt_d;
  logic                           out_valid_q, out_valid_d;
  logic [tses_pkg::N_W-1:0]       n_cl;

  always_comb begin
    if ({1'b0, term_count_i} > (tses_pkg::N_W + 1)'(MAX_TERMS)) begin
      n_cl = tses_pkg::N_W'(MAX_TERMS);
    end else begin
      n_cl = term_count_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    limit_d     = limit_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.idx   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = tses_pkg::N_W'(1);
          if (kind_i == tses_pkg::KIND_SINE) begin
            limit_d = (n_cl < tses_pkg::N_W'(2)) ? tses_pkg::N_W'(1) : n_cl;
            state_d = S_PREP;
          end else if (n_cl == tses_pkg::N_W'(1)) begin
            state_d = S_DONE;
          end else begin
            limit_d = (n_cl == '0) ? tses_pkg::N_W'(1) : n_cl - tses_pkg::N_W'(1);
            state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        dcnt_d     = '0;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + tses_pkg::DCNT_W'(1);
        if (dcnt_q == tses_pkg::DCNT_W'(tses_pkg::DIV_CYCLES - 1)) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (idx_q == limit_q) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + tses_pkg::N_W'(1);
          state_d = S_PREP;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      limit_q     <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      limit_q     <= limit_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/tses_dp.sv
`default_nettype none

module tses_dp #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                            clk_i,
  input  wire logic                            kind_i,
  input  wire logic [tses_pkg::X_W-1:0]        x_value_i,
  input  wire tses_pkg::dp_cmd_t               cmd_i,
  output logic signed [tses_pkg::SUM_W-1:0]    series_sum_o
);

  localparam int unsigned TW = tses_pkg::TERM_W;
  localparam int unsigned SW = tses_pkg::SUM_W;
  localparam int unsigned PW = tses_pkg::P_W;
  localparam int unsigned DW = tses_pkg::DIV_W;
  localparam int unsigned PEW = TW + tses_pkg::X_W;
  localparam int unsigned PSW = TW + tses_pkg::SQ_W;
  localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;
  localparam logic [SW-1:0] POS_CAP = {1'b0, {(SW - 1){1'b1}}};

  logic                          kind_q;
  logic [tses_pkg::X_W-1:0]      x_q;
  logic [tses_pkg::SQ_W-1:0]     xsq_q;
  logic [TW-1:0]                 term_q;
  logic [SW-1:0]                 sum_q;
  logic [PW-1:0]                 dq_q;
  logic [DW-1:0]                 rem_q;
  logic [DW-1:0]                 div_q;
  logic [SW-1:0]                 out_q;

  logic                                   is_sine;
  logic                                   first_sine;
  logic [PEW-1:0]                         prod_exp;
  logic [PSW-1:0]                         prod_sine;
  logic [tses_pkg::N_W-1:0]               jm1;
  logic [tses_pkg::N_W:0]                 j2m1;
  logic [tses_pkg::CORE_W-1:0]            core;
  logic [DW-1:0]                          div_sine;
  logic [PW-1:0]                          prep_dvd;
  logic [DW-1:0]                          prep_div;
  logic [PW-1:0]                          dq_v;
  logic [DW-1:0]                          rem_v;
  logic [DW:0]                            trial;
  logic [TW-1:0]                          term_new;
  logic [SW-1:0]                          sum_add;
  logic [SW-1:0]                          sum_new;

  assign is_sine    = (kind_q == tses_pkg::KIND_SINE);
  assign first_sine = is_sine && (cmd_i.idx == tses_pkg::N_W'(1));

  assign prod_exp  = PEW'(term_q) * PEW'(x_q);
  assign prod_sine = PSW'(term_q) * PSW'(xsq_q);
  assign jm1       = cmd_i.idx - tses_pkg::N_W'(1);
  assign j2m1      = {cmd_i.idx, 1'b0} - (tses_pkg::N_W + 1)'(1);
  assign core      = tses_pkg::CORE_W'(jm1) * tses_pkg::CORE_W'(j2m1);
  assign div_sine  = DW'(core) * DW'(tses_pkg::SINE_SCALE);

  always_comb begin
    if (first_sine) begin
      prep_dvd = PW'(x_q) << FRAC_BITS;
      prep_div = DW'(tses_pkg::SINE_FIRST_DIV);
    end else if (is_sine) begin
      prep_dvd = PW'(prod_sine >> tses_pkg::SINE_PRE_SHIFT);
      prep_div = div_sine;
    end else begin
      prep_dvd = PW'(prod_exp);
      prep_div = DW'(cmd_i.idx);
    end
  end

  always_comb begin
    dq_v  = dq_q;
    rem_v = rem_q;
    trial = '0;
    for (int unsigned i = 0; i < tses_pkg::STEP_BITS; i++) begin
      trial = {rem_v, dq_v[PW-1]};
      dq_v  = dq_v << 1;
      if (trial >= {1'b0, div_q}) begin
        rem_v   = DW'(trial - {1'b0, div_q});
        dq_v[0] = 1'b1;
      end else begin
        rem_v = DW'(trial);
      end
    end
  end

  always_comb begin
    if (|dq_q[PW-1:TW]) begin
      term_new = {TW{1'b1}};
    end else begin
      term_new = dq_q[TW-1:0];
    end
    sum_add = sum_q + {1'b0, term_new};
    if (!is_sine) begin
      sum_new = sum_add[SW-1] ? POS_CAP : sum_add;
    end else if (cmd_i.idx == tses_pkg::N_W'(1)) begin
      sum_new = {1'b0, term_new};
    end else if (!cmd_i.idx[0]) begin
      sum_new = sum_q - {1'b0, term_new};
    end else begin
      sum_new = sum_add;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      x_q    <= x_value_i;
      xsq_q  <= tses_pkg::SQ_W'(x_value_i) * tses_pkg::SQ_W'(x_value_i);
      term_q <= ONE;
      sum_q  <= {1'b0, ONE};
    end
    if (cmd_i.prep) begin
      dq_q  <= prep_dvd;
      div_q <= prep_div;
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      dq_q  <= dq_v;
      rem_q <= rem_v;
    end
    if (cmd_i.acc) begin
      term_q <= term_new;
      sum_q  <= sum_new;
    end
    if (cmd_i.publish) begin
      out_q <= sum_q;
    end
  end

  assign series_sum_o = out_q;

endmodule

`default_nettype wire

### rtl/taylor_series_exp_sine.sv
// Truncated Taylor sum of e^x or sin(x/10) as a signed value with FRAC_BITS
// fraction bits. A request on the input channel carries kind_i (0 for exp,
// 1 for sine), x_value_i and term_count_i, and is taken when in_valid_i is
// high and in_stall_o is low. The block works on one request at a time.
// Each computed series term takes a multiply step, the steps of the shared
// radix-256 divider and an accumulate step. The first exp term is the
// constant one and costs nothing; every sine term is computed. An exp
// request with n terms computes n - 1 of them (none for one term, one for
// zero terms); a sine request computes max(n, 1). The result becomes valid
// in the same cycle in which the next request can be taken. The term count
// is clamped to MAX_TERMS.
// The result stands on series_sum_o while out_valid_o is high and is taken
// when out_stall_i is low. While the receiver stalls, the next request is
// still accepted and computed; it waits for the output register to free up.
// Reset clears the controller and drops out_valid_o; no clearing pass runs.
`default_nettype none

module taylor_series_exp_sine #(
  parameter int unsigned FRAC_BITS = 24,
  parameter int unsigned MAX_TERMS = 26
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            kind_i,
  input  wire logic [tses_pkg::X_W-1:0]        x_value_i,
  input  wire logic [tses_pkg::N_W-1:0]        term_count_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [tses_pkg::SUM_W-1:0]    series_sum_o
);

  tses_pkg::dp_cmd_t cmd;

  tses_ctrl #(
    .MAX_TERMS(MAX_TERMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .term_count_i(term_count_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  tses_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .kind_i      (kind_i),
    .x_value_i   (x_value_i),
    .cmd_i       (cmd),
    .series_sum_o(series_sum_o)
  );

endmodule

`default_nettype wire

### test/taylor_series_exp_sine_tb.sv
`timescale 1ns / 100ps

module taylor_series_exp_sine_tb;

  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned MAX_TERMS = 26;
  localparam int unsigned RANDOM_REQUESTS = 1550;
  localparam int unsigned CALM_REQUESTS = 150;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam logic [63:0] POS_CAP = 64'h7FFF_FFFF_FFFF_FFFF;

  class SeriesScoreboard;
    logic [63:0] pending_sums[$];
    int unsigned errors;

    function logic [63:0] scaled_floor(logic [63:0] t, logic [63:0] m, logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] hi;
      logic [63:0] lo;
      q = t / d;
      r = t % d;
      if (m != 0 && q > POS_CAP / m) return POS_CAP;
      hi = q * m;
      lo = (r * m) / d;
      if (hi > POS_CAP - lo) return POS_CAP;
      return hi + lo;
    endfunction

    function logic [63:0] capped_add(logic [63:0] a, logic [63:0] b);
      if (a > POS_CAP - b) return POS_CAP;
      return a + b;
    endfunction

    function logic [63:0] exp_sum(logic [63:0] x, logic [63:0] n);
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] terms;
      term = 64'd1 << FRAC_BITS;
      sum = term;
      terms = n;
      if (terms == 1) return sum;
      if (terms == 0) terms = 2;
      for (logic [63:0] k = 1; k < terms; k++) begin
        term = scaled_floor(term, x, k);
        sum = capped_add(sum, term);
      end
      return sum;
    endfunction

    function logic [63:0] sine_sum(logic [63:0] x, logic [63:0] n);
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] d;
      bit negative;
      term = (x * (64'd1 << FRAC_BITS)) / 10;
      sum = term;
      negative = 1'b1;
      for (logic [63:0] j = 2; j <= n; j++) begin
        d = 100 * (2 * j - 2) * (2 * j - 1);
        term = scaled_floor(term, x * x, d);
        if (negative) sum = sum - term;
        else sum = sum + term;
        negative = !negative;
      end
      return sum;
    endfunction

    function void note_request(logic kind, logic [4:0] x, logic [4:0] n);
      logic [63:0] terms;
      terms = {59'd0, n};
      if (terms > 64'(MAX_TERMS)) terms = 64'(MAX_TERMS);
      if (kind == tses_pkg::KIND_EXP) pending_sums.push_back(exp_sum({59'd0, x}, terms));
      else pending_sums.push_back(sine_sum({59'd0, x}, terms));
    endfunction

    function void check_sum(logic [63:0] actual);
      logic [63:0] expected;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected series_sum, expected none, actual %h", $time, actual);
        errors++;
        return;
      end
      expected = pending_sums.pop_front();
      if (actual !== expected) begin
        $display("%0t: series_sum mismatch, expected %h, actual %h", $time, expected, actual);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic kind_i = 1'b0;
  logic [tses_pkg::X_W-1:0] x_value_i = '0;
  logic [tses_pkg::N_W-1:0] term_count_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic signed [tses_pkg::SUM_W-1:0] series_sum_o;

  SeriesScoreboard sums;
  bit calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  taylor_series_exp_sine #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_TERMS(MAX_TERMS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .kind_i(kind_i),
    .x_value_i(x_value_i),
    .term_count_i(term_count_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .series_sum_o(series_sum_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sums.note_request(kind_i, x_value_i, term_count_i);
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid_o && !out_stall_i) begin
        sums.check_sum(series_sum_o);
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_stall_i <= 1'b0;
    end else if (!calm && rst_ni && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13);
      out_stall_i <= 1'b1;
    end
  end

  task automatic send_request(input logic kind, input logic [4:0] x, input logic [4:0] n);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    x_value_i <= x;
    term_count_i <= n;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random_request();
    logic kind;
    logic [4:0] x;
    logic [4:0] n;
    kind = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) x = 5'($urandom_range(0, 31));
    else x = 5'($urandom_range(0, 25));
    if ($urandom_range(0, 9) == 0) n = 5'($urandom_range(0, 31));
    else n = 5'($urandom_range(0, 26));
    send_request(kind, x, n);
  endtask

  initial begin
    sums = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(tses_pkg::KIND_EXP, 5'd0, 5'd0);
    send_request(tses_pkg::KIND_EXP, 5'd7, 5'd0);
    send_request(tses_pkg::KIND_EXP, 5'd25, 5'd1);
    send_request(tses_pkg::KIND_EXP, 5'd3, 5'd2);
    send_request(tses_pkg::KIND_EXP, 5'd1, 5'd26);
    send_request(tses_pkg::KIND_EXP, 5'd25, 5'd26);
    send_request(tses_pkg::KIND_EXP, 5'd31, 5'd26);
    send_request(tses_pkg::KIND_EXP, 5'd31, 5'd31);
    send_request(tses_pkg::KIND_EXP, 5'd0, 5'd31);
    send_request(tses_pkg::KIND_EXP, 5'd21, 5'd10);
    send_request(tses_pkg::KIND_EXP, 5'd10, 5'd21);
    send_request(tses_pkg::KIND_SINE, 5'd0, 5'd0);
    send_request(tses_pkg::KIND_SINE, 5'd15, 5'd0);
    send_request(tses_pkg::KIND_SINE, 5'd15, 5'd1);
    send_request(tses_pkg::KIND_SINE, 5'd1, 5'd2);
    send_request(tses_pkg::KIND_SINE, 5'd25, 5'd26);
    send_request(tses_pkg::KIND_SINE, 5'd31, 5'd26);
    send_request(tses_pkg::KIND_SINE, 5'd31, 5'd31);
    send_request(tses_pkg::KIND_SINE, 5'd0, 5'd31);
    send_request(tses_pkg::KIND_SINE, 5'd21, 5'd10);
    send_request(tses_pkg::KIND_SINE, 5'd10, 5'd21);
    send_request(tses_pkg::KIND_SINE, 5'd16, 5'd3);

    for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS - CALM_REQUESTS) calm = 1'b1;
      send_random_request();
    end
    in_valid_i <= 1'b0;

    while (sums.pending_sums.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sums.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### taylor_series_exp_sine.f
rtl/tses_pkg.sv
rtl/tses_ctrl.sv
rtl/tses_dp.sv
rtl/taylor_series_exp_sine.sv
test/taylor_series_exp_sine_tb.sv
